// ===== design/cksr_pkg.sv =====
// Shared types and constants for the checkpoint slot replacement core.
// No dependencies; imported by every module of the block.
package cksr_pkg;

    // operation codes (s_axis_tuser[1:0])
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_ERASE    = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_NO_VICTIM = 2'd2;

    localparam int          WEIGHT_W   = 8;
    localparam logic [7:0]  WEIGHT_MAX = 8'd255;
    localparam int          CAP_W      = 6;
    localparam logic [5:0]  EXTRA_MAX  = 6'd63;
    localparam int          OUT_STEP_W = 32;
    localparam int          CNT_OUT_W  = 6;
    localparam int          IN_USER_W  = 3;
    localparam int          OUT_DATA_W = 80;
    localparam int          PROD_W     = 64;

    // gap product unit response
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== design/cksr_mem.sv =====
// Slot store: one write port, one read port, registered read data.
// Depends on cksr_pkg.
module cksr_mem
    import cksr_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 41
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cksr_mul.sv =====
// Gap product unit: W x W multiply, one byte of the multiplier per cycle,
// result saturated to 64 bits. Depends on cksr_pkg.
module cksr_mul
    import cksr_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_mul_rsp     o_rsp
);

    localparam int PW  = 2 * W;
    localparam int ND  = (W + 7) / 8;
    localparam int NCW = $clog2(ND + 1);

    logic [PW-1:0]  r_a;
    logic [W-1:0]   r_b;
    logic [PW-1:0]  r_acc;
    logic [NCW-1:0] r_n;
    logic           r_busy;
    logic           r_done;
    logic [PW-1:0]  pp;
    logic [127:0]   wide;

    assign pp   = PW'(r_a * r_b[7:0]);
    assign wide = 128'(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_n    <= NCW'(ND);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + pp;
                r_a   <= r_a << 8;
                r_b   <= r_b >> 8;
                r_n   <= r_n - 1'b1;
                if (r_n == NCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = (|wide[127:64]) ? {PROD_W{1'b1}} : wide[63:0];

endmodule

// ===== design/checkpoint_slot_replacement_core.sv =====
// Top level of the checkpoint slot replacement core: sequencer around the
// slot store and the gap product unit. Depends on cksr_pkg, cksr_mem, cksr_mul.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: step; tuser: op, persistent
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: one result per request
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | base_capacity
//
//  One request at a time. Each slot visit is a memory read, then an act/write step.
//  Contains and erase scan slots until a match; clear scans every slot; add scans every
//  slot, may rescan all slots for the weighted victim search with one gap product per
//  candidate, and shifts slots on remove and insert (erase shifts on remove too).
//  The slot store has a single read port and the gap multiplier is byte-serial.
//  Reset (synchronous, active low) empties the table; the store itself is not
//  cleared since entries at or above the count are never read.
//  A request is taken while an earlier result still waits on m_axis.
module checkpoint_slot_replacement_core
    import cksr_pkg::*;
#(
    parameter int MAX_SLOTS = 32,
    parameter int STEP_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // step
    input  logic [((STEP_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // operation[1:0], persistent[2]
    input  logic [IN_USER_W-1:0]                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // evicted_valid[0], evicted_step[32:1], hit[33], slot_count[39:34],
    // last_step[71:40], error[73:72], zero fill
    output logic [OUT_DATA_W-1:0]                m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CAP_W-1:0]                     i_cfg_data
);

    localparam int SB = STEP_BITS;
    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = SB + WEIGHT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_P1_RD, S_P1_EX, S_P1_END,
        S_P2_RD, S_P2_EX, S_P2_MUL, S_P2_TAIL,
        S_RM_CHK, S_RM_RD, S_RM_EX, S_RM_END,
        S_IN_CHK, S_IN_RD, S_IN_EX, S_IN_PUT,
        S_LK_RD, S_LK_EX, S_CL_RD, S_CL_EX,
        S_FIN_RD, S_FIN_EX, S_DONE
    } t_state;

    t_state r_state;

    // request
    logic [1:0]      r_op;
    logic [SB-1:0]   r_step;
    logic            r_perm;
    // table state
    logic [CW-1:0]   r_cnt;
    logic [5:0]      r_extra;
    logic [5:0]      r_base;
    // loop indexes
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_k;
    // first scan
    logic [CW-1:0]   r_less;
    logic [7:0]      r_maxw;
    logic [7:0]      r_dw;
    logic            r_dw_fnd;
    logic            r_rnp_fnd;
    logic [CW-1:0]   r_rnp_idx;
    logic [7:0]      r_rnp_w;
    logic [SB-1:0]   r_rnp_step;
    // weighted victim search
    logic            r_seen_hi;
    logic [SB-1:0]   r_prev_step;
    logic            r_cur_cand;
    logic [SB-1:0]   r_cur_step;
    logic [SB-1:0]   r_cur_right;
    logic [CW-1:0]   r_cur_idx;
    logic [CW-1:0]   r_pend_idx;
    logic [SB-1:0]   r_pend_step;
    logic            r_best_fnd;
    logic [PROD_W-1:0] r_best_p;
    logic [CW-1:0]   r_best_idx;
    logic [SB-1:0]   r_best_step;
    // victim and new slot
    logic [CW-1:0]   r_vic;
    logic [7:0]      r_new_w;
    // result
    logic            r_evict;
    logic [SB-1:0]   r_vic_step;
    logic            r_hit;
    logic [1:0]      r_err;
    logic [SB-1:0]   r_last;
    logic            r_ovalid;
    logic [OUT_DATA_W-1:0] r_otdata;

    // memory ports
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic [SB-1:0] rd_step;
    logic [7:0]    rd_w;
    logic          rd_perm;

    logic          mul_start;
    logic [SB-1:0] mul_a;
    logic [SB-1:0] mul_b;
    t_mul_rsp      mul_rsp;

    logic [9:0]    cnt_x;
    logic [6:0]    cap_sum;
    logic [9:0]    cap_np;
    logic [5:0]    ex_sat;
    logic          evict_np;
    logic          full_p;
    logic          lk_match;

    assign rd_step = mem_rdata[SB-1:0];
    assign rd_w    = mem_rdata[SB+WEIGHT_W-1:SB];
    assign rd_perm = mem_rdata[EW-1];

    // capacity checks
    assign cnt_x    = 10'(r_cnt);
    assign cap_sum  = 7'(r_base) + 7'(r_extra);
    assign cap_np   = (10'(cap_sum) > 10'(MAX_SLOTS)) ? 10'(MAX_SLOTS) : 10'(cap_sum);
    assign ex_sat   = (r_extra == EXTRA_MAX) ? EXTRA_MAX : r_extra + 6'd1;
    assign evict_np = cnt_x >= cap_np;
    assign full_p   = (cnt_x >= 10'(MAX_SLOTS)) || (cnt_x >= 10'(7'(r_base) + 7'(ex_sat)));
    assign lk_match = (rd_step == r_step) && ((r_op == OP_CONTAINS) || !rd_perm);

    // gap product operands: left neighbor is the slot just read, or step 0
    assign mul_start = ((r_state == S_P2_EX) || (r_state == S_P2_TAIL)) && r_cur_cand;
    assign mul_a     = (r_state == S_P2_TAIL) ? r_cur_step : r_cur_step - rd_step;
    assign mul_b     = r_cur_right - r_cur_step;

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_i[IW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_i[IW-1:0];
        mem_wdata = mem_rdata;
        case (r_state)
            S_P1_RD, S_P2_RD, S_LK_RD, S_CL_RD: begin
                mem_re = 1'b1;
            end
            S_RM_RD: begin
                mem_re    = 1'b1;
                mem_raddr = IW'(r_i + 1'b1);
            end
            S_IN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = IW'(r_i - 1'b1);
            end
            S_FIN_RD: begin
                mem_re    = (r_cnt != '0);
                mem_raddr = IW'(r_cnt - 1'b1);
            end
            S_RM_EX, S_IN_EX: begin
                mem_we = 1'b1;
            end
            S_CL_EX: begin
                mem_we    = rd_perm;
                mem_waddr = r_k[IW-1:0];
            end
            S_IN_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IW-1:0];
                mem_wdata = {r_perm, r_new_w, r_step};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_extra  <= '0;
            r_base   <= 6'd8;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            // S_DONE sets valid itself
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= s_axis_tuser[1:0];
                        r_perm     <= s_axis_tuser[2];
                        r_step     <= s_axis_tdata[SB-1:0];
                        r_evict    <= 1'b0;
                        r_vic_step <= '0;
                        r_hit      <= 1'b0;
                        r_err      <= ERR_NONE;
                        r_state    <= S_START;
                    end
                end
                S_START: begin
                    r_less     <= '0;
                    r_maxw     <= '0;
                    r_dw_fnd   <= 1'b0;
                    r_rnp_fnd  <= 1'b0;
                    r_seen_hi  <= 1'b0;
                    r_cur_cand <= 1'b0;
                    r_best_fnd <= 1'b0;
                    r_new_w    <= '0;
                    r_k        <= '0;
                    case (r_op)
                        OP_ADD: begin
                            if (r_perm && full_p) begin
                                r_err   <= ERR_OVERFLOW;
                                r_state <= S_FIN_RD;
                            end else if (r_cnt == '0) begin
                                r_state <= S_P1_END;
                            end else begin
                                r_i     <= r_cnt - 1'b1;
                                r_state <= S_P1_RD;
                            end
                        end
                        OP_ERASE, OP_CONTAINS, OP_CLEAR: begin
                            r_i <= '0;
                            if (r_cnt == '0) begin
                                r_state <= S_FIN_RD;
                            end else if (r_op == OP_CLEAR) begin
                                r_state <= S_CL_RD;
                            end else begin
                                r_state <= S_LK_RD;
                            end
                        end
                        default: r_state <= S_FIN_RD;
                    endcase
                end
                // first scan, right to left: insert position, first weight
                // that lies behind a higher one, rightmost evictable slot
                S_P1_RD: r_state <= S_P1_EX;
                S_P1_EX: begin
                    if (rd_step < r_step) begin
                        r_less <= r_less + 1'b1;
                    end
                    if (!rd_perm) begin
                        if (!r_rnp_fnd) begin
                            r_rnp_fnd  <= 1'b1;
                            r_rnp_idx  <= r_i;
                            r_rnp_w    <= rd_w;
                            r_rnp_step <= rd_step;
                        end
                        if (!r_dw_fnd) begin
                            if (rd_w < r_maxw) begin
                                r_dw_fnd <= 1'b1;
                                r_dw     <= rd_w;
                            end else if (rd_w > r_maxw) begin
                                r_maxw <= rd_w;
                            end
                        end
                    end
                    if (r_i == '0) begin
                        r_state <= S_P1_END;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_P1_RD;
                    end
                end
                S_P1_END: begin
                    if (r_perm) begin
                        r_extra <= ex_sat;
                        r_new_w <= WEIGHT_MAX;
                        r_i     <= r_cnt;
                        r_k     <= r_less;
                        r_state <= S_IN_CHK;
                    end else if (!evict_np) begin
                        r_i     <= r_cnt;
                        r_k     <= r_less;
                        r_state <= S_IN_CHK;
                    end else if (r_dw_fnd) begin
                        r_i     <= r_cnt - 1'b1;
                        r_state <= S_P2_RD;
                    end else if (r_rnp_fnd) begin
                        r_evict    <= 1'b1;
                        r_vic      <= r_rnp_idx;
                        r_i        <= r_rnp_idx;
                        r_vic_step <= r_rnp_step;
                        r_new_w    <= (r_rnp_w == WEIGHT_MAX) ? WEIGHT_MAX : r_rnp_w + 8'd1;
                        r_state    <= S_RM_CHK;
                    end else begin
                        r_err   <= ERR_NO_VICTIM;
                        r_state <= S_FIN_RD;
                    end
                end
                // second scan, right to left; a candidate is scored once
                // its left neighbor has been read
                S_P2_RD: r_state <= S_P2_EX;
                S_P2_EX: begin
                    if (r_cur_cand) begin
                        r_pend_idx  <= r_cur_idx;
                        r_pend_step <= r_cur_step;
                    end
                    r_cur_cand  <= !rd_perm && (rd_w == r_dw) && r_seen_hi;
                    r_cur_step  <= rd_step;
                    r_cur_right <= r_prev_step;
                    r_cur_idx   <= r_i;
                    r_prev_step <= rd_step;
                    if (!rd_perm && (rd_w > r_dw)) begin
                        r_seen_hi <= 1'b1;
                    end
                    if (r_cur_cand) begin
                        r_state <= S_P2_MUL;
                    end else if (r_i == '0) begin
                        r_state <= S_P2_TAIL;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_P2_RD;
                    end
                end
                S_P2_MUL: begin
                    if (mul_rsp.done) begin
                        // ties go to the lower index, which comes later here
                        if (!r_best_fnd || (mul_rsp.prod <= r_best_p)) begin
                            r_best_fnd  <= 1'b1;
                            r_best_p    <= mul_rsp.prod;
                            r_best_idx  <= r_pend_idx;
                            r_best_step <= r_pend_step;
                        end
                        if (r_i == '0) begin
                            r_state <= S_P2_TAIL;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_state <= S_P2_RD;
                        end
                    end
                end
                S_P2_TAIL: begin
                    if (r_cur_cand) begin
                        r_pend_idx  <= r_cur_idx;
                        r_pend_step <= r_cur_step;
                        r_cur_cand  <= 1'b0;
                        r_state     <= S_P2_MUL;
                    end else begin
                        r_evict    <= 1'b1;
                        r_vic      <= r_best_idx;
                        r_i        <= r_best_idx;
                        r_vic_step <= r_best_step;
                        r_new_w    <= '0;
                        r_state    <= S_RM_CHK;
                    end
                end
                // remove: shift slots above the victim down by one
                S_RM_CHK: begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_state <= S_RM_END;
                    end else begin
                        r_state <= S_RM_RD;
                    end
                end
                S_RM_RD: r_state <= S_RM_EX;
                S_RM_EX: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_RM_CHK;
                end
                S_RM_END: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_op == OP_ADD) begin
                        r_i     <= r_cnt - 1'b1;
                        r_k     <= (r_vic < r_less) ? r_less - 1'b1 : r_less;
                        r_state <= S_IN_CHK;
                    end else begin
                        r_state <= S_FIN_RD;
                    end
                end
                // insert: shift slots at and above the position up by one
                S_IN_CHK: begin
                    if (r_i == r_k) begin
                        r_state <= S_IN_PUT;
                    end else begin
                        r_state <= S_IN_RD;
                    end
                end
                S_IN_RD: r_state <= S_IN_EX;
                S_IN_EX: begin
                    r_i     <= r_i - 1'b1;
                    r_state <= S_IN_CHK;
                end
                S_IN_PUT: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_FIN_RD;
                end
                // erase / contains lookup, left to right
                S_LK_RD: r_state <= S_LK_EX;
                S_LK_EX: begin
                    if (lk_match) begin
                        r_hit <= 1'b1;
                        if (r_op == OP_ERASE) begin
                            r_vic   <= r_i;
                            r_state <= S_RM_CHK;
                        end else begin
                            r_state <= S_FIN_RD;
                        end
                    end else if (r_i == r_cnt - 1'b1) begin
                        r_state <= S_FIN_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LK_RD;
                    end
                end
                // clear: compact persistent slots toward index 0
                S_CL_RD: r_state <= S_CL_EX;
                S_CL_EX: begin
                    if (rd_perm) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (r_i == r_cnt - 1'b1) begin
                        r_cnt   <= r_k + CW'(rd_perm);
                        r_state <= S_FIN_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CL_RD;
                    end
                end
                S_FIN_RD: begin
                    if (r_cnt == '0) begin
                        r_last  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FIN_EX;
                    end
                end
                S_FIN_EX: begin
                    r_last  <= rd_step;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_otdata <= {6'd0, r_err, OUT_STEP_W'(r_last), CNT_OUT_W'(r_cnt),
                                     r_hit, OUT_STEP_W'(r_vic_step), r_evict};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    cksr_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW),
        .DW    (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cksr_mul #(
        .W (SB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== design/cksr_chk.sv =====
// Port-level checker for the checkpoint slot replacement core, with its bind.
// Depends on cksr_pkg and checkpoint_slot_replacement_core.
module cksr_chk
    import cksr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_evict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[73:72] == ERR_NONE) && !m_axis_tdata[33])
        else $error("eviction reported with error or hit");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[73:72] != ERR_NONE) |->
            !m_axis_tdata[0] && !m_axis_tdata[33] && (m_axis_tdata[32:1] == '0))
        else $error("error result carries eviction or hit");

endmodule

bind checkpoint_slot_replacement_core cksr_chk u_cksr_chk (.*);

// ===== bench/tb.sv =====
// Self-checking bench for checkpoint_slot_replacement_core: directed and random
// requests against an in-bench slot table model. Depends on cksr_pkg and the RTL.
module tb
    import cksr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;

    // lowest field in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] last;
        logic [5:0]  count;
        logic        hit;
        logic [31:0] ev_step;
        logic        ev_valid;
    } t_result;

    typedef bit  bool_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [2:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [5:0]        i_cfg_data = '0;

    checkpoint_slot_replacement_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // slot table model
    logic [31:0] tbl_step [NSLOT];
    logic [7:0]  tbl_wt   [NSLOT];
    logic        tbl_perm [NSLOT];
    int unsigned tbl_n, tbl_extra, tbl_base;

    t_result     pending_q[$];
    int          n_errors;
    bool_t       stall_long;
    int          idle_max;     // max per-request gap, 0 disables idling

    task automatic report(input string what, input logic [79:0] got, input logic [79:0] exp_v);
        $display("tb: mismatch %s got %h want %h", what, got, exp_v);
        n_errors++;
    endtask

    function automatic void tbl_remove(int unsigned idx);
        for (int unsigned k = idx; k + 1 < tbl_n; k++) begin
            tbl_step[k] = tbl_step[k+1];
            tbl_wt[k]   = tbl_wt[k+1];
            tbl_perm[k] = tbl_perm[k+1];
        end
        tbl_n--;
    endfunction

    function automatic void tbl_insert(logic [31:0] st, logic [7:0] w, logic p);
        int unsigned pos;
        pos = 0;
        while (pos < tbl_n && tbl_step[pos] < st) pos++;
        for (int unsigned k = tbl_n; k > pos; k--) begin
            tbl_step[k] = tbl_step[k-1];
            tbl_wt[k]   = tbl_wt[k-1];
            tbl_perm[k] = tbl_perm[k-1];
        end
        tbl_step[pos] = st;
        tbl_wt[pos]   = w;
        tbl_perm[pos] = p;
        tbl_n++;
    endfunction

    // weighted victim: slot behind a higher weight with the smallest gap product
    function automatic int unsigned pick_weighted_victim();
        int unsigned maxw, dw, best;
        bit          found, higher;
        logic [63:0] gl, gr, prod, bestp;
        logic [31:0] left;
        maxw = 0; dw = 0; found = 0; best = tbl_n; bestp = '0;
        for (int i = int'(tbl_n) - 1; i >= 0; i--) begin
            if (tbl_perm[i]) continue;
            if (tbl_wt[i] < maxw) begin
                dw = tbl_wt[i];
                found = 1;
                break;
            end
            if (tbl_wt[i] > maxw) maxw = tbl_wt[i];
        end
        if (!found) return tbl_n;
        found = 0;
        for (int unsigned i = 0; i < tbl_n; i++) begin
            if (tbl_perm[i] || tbl_wt[i] != dw) continue;
            higher = 0;
            for (int unsigned j = i + 1; j < tbl_n; j++)
                if (!tbl_perm[j] && tbl_wt[j] > dw) begin
                    higher = 1;
                    break;
                end
            if (!higher) continue;
            left = (i > 0) ? tbl_step[i-1] : 32'd0;
            gl = {32'd0, 32'(tbl_step[i] - left)};
            gr = {32'd0, 32'(tbl_step[i+1] - tbl_step[i])};
            prod = gl * gr; // 32x32 never saturates 64 bits
            if (!found || prod < bestp) begin
                found = 1;
                bestp = prod;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_result predict_request(logic [1:0] op, logic [31:0] st, logic p);
        t_result     r;
        int unsigned ex, cap, idx;
        logic [7:0]  w;
        r = '0;
        w = 8'd0;
        case (op)
            OP_ADD: begin
                if (p) begin
                    ex = (tbl_extra < EXTRA_MAX) ? tbl_extra + 1 : EXTRA_MAX;
                    cap = tbl_base + ex;
                    if (tbl_n >= NSLOT || tbl_n >= cap) r.err = ERR_OVERFLOW;
                    else begin
                        tbl_extra = ex;
                        tbl_insert(st, WEIGHT_MAX, 1'b1);
                    end
                end else begin
                    cap = tbl_base + tbl_extra;
                    if (cap > NSLOT) cap = NSLOT;
                    if (tbl_n >= cap) begin
                        idx = pick_weighted_victim();
                        if (idx >= tbl_n) begin
                            // fallback: rightmost non-persistent, inherits weight + 1
                            for (int i = int'(tbl_n) - 1; i >= 0; i--)
                                if (!tbl_perm[i]) begin
                                    idx = i;
                                    break;
                                end
                            if (idx < tbl_n)
                                w = (tbl_wt[idx] < WEIGHT_MAX) ? tbl_wt[idx] + 8'd1 : WEIGHT_MAX;
                        end
                        if (idx >= tbl_n) r.err = ERR_NO_VICTIM;
                        else begin
                            r.ev_valid = 1'b1;
                            r.ev_step = tbl_step[idx];
                            tbl_remove(idx);
                        end
                    end
                    if (r.err == ERR_NONE) tbl_insert(st, w, 1'b0);
                end
            end
            OP_ERASE: begin
                for (int unsigned i = 0; i < tbl_n; i++)
                    if (tbl_step[i] == st && !tbl_perm[i]) begin
                        tbl_remove(i);
                        r.hit = 1'b1;
                        break;
                    end
            end
            OP_CONTAINS: begin
                for (int unsigned i = 0; i < tbl_n; i++)
                    if (tbl_step[i] == st) begin
                        r.hit = 1'b1;
                        break;
                    end
            end
            default: begin
                idx = 0;
                for (int unsigned i = 0; i < tbl_n; i++)
                    if (tbl_perm[i]) begin
                        tbl_step[idx] = tbl_step[i];
                        tbl_wt[idx] = tbl_wt[i];
                        tbl_perm[idx] = 1'b1;
                        idx++;
                    end
                tbl_n = idx;
            end
        endcase
        r.count = 6'(tbl_n);
        r.last = tbl_n ? tbl_step[tbl_n-1] : 32'd0;
        return r;
    endfunction

    // send one request; the model runs at acceptance. Valid stays up after an
    // accept until the next request either idles or replaces it.
    task automatic send_request(logic [1:0] op, logic [31:0] st, logic p);
        int gap;
        gap = idle_max ? $urandom_range(idle_max, 0) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= st;
        s_axis_tuser  <= {p, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(predict_request(op, st, p));
    endtask

    // checker and receiver stall
    initial begin
        t_result got, want;
        int      wait_n;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[73:0]);
                if (pending_q.size() == 0) report("unexpected result", 80'(got), '0);
                else begin
                    want = pending_q.pop_front();
                    if (got.ev_valid != want.ev_valid)
                        report("evicted_valid", 80'(got.ev_valid), 80'(want.ev_valid));
                    if (got.ev_step != want.ev_step)
                        report("evicted_step", 80'(got.ev_step), 80'(want.ev_step));
                    if (got.hit != want.hit) report("hit", 80'(got.hit), 80'(want.hit));
                    if (got.count != want.count)
                        report("slot_count", 80'(got.count), 80'(want.count));
                    if (got.last != want.last)
                        report("last_step", 80'(got.last), 80'(want.last));
                    if (got.err != want.err) report("error", 80'(got.err), 80'(want.err));
                end
            end
            if (stall_long) wait_n = 600;
            else wait_n = (idle_max && $urandom_range(3, 0) == 0) ?
                $urandom_range(idle_max, 1) : 0;
            if (wait_n) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [5:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_base = v;
    endtask

    // step values kept near each other so duplicates and lookups hit
    function automatic logic [31:0] pick_step(logic [31:0] base_v);
        case ($urandom_range(9, 0))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            2: return tbl_n ? tbl_step[$urandom_range(tbl_n - 1, 0)] : base_v;
            default: return base_v + $urandom_range(60, 0);
        endcase
    endfunction

    task automatic test_directed();
        send_request(OP_CONTAINS, 32'd0, 1'b0);
        send_request(OP_ERASE, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_CLEAR, 32'd0, 1'b0);
        // fill past capacity 8, force both eviction kinds
        for (int i = 0; i < 10; i++) send_request(OP_ADD, 32'(i * 10 + (i % 3)), 1'b0);
        send_request(OP_ADD, 32'd5, 1'b1);
        send_request(OP_ADD, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_CONTAINS, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ERASE, 32'hFFFF_FFFF, 1'b0);   // persistent: no hit
        send_request(OP_ERASE, 32'd20, 1'b0);
        send_request(OP_ADD, 32'd20, 1'b0);
        send_request(OP_ADD, 32'd20, 1'b0);             // duplicate step
        send_request(OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_ADD, 32'd0, 1'b0);
    endtask

    // capacity 1 with persistent and plain adds and a clear, then a full table shrunk to capacity 2
    task automatic test_capacity_extremes();
        write_capacity(6'd1);
        send_request(OP_ADD, 32'd7, 1'b1);
        send_request(OP_ADD, 32'd8, 1'b1);
        send_request(OP_ADD, 32'd9, 1'b0);
        send_request(OP_CLEAR, 32'd0, 1'b0);
        send_request(OP_ADD, 32'd1, 1'b0);
        write_capacity(6'd63);
        for (int i = 0; i < 36; i++) send_request(OP_ADD, $urandom(), i[0]);
        write_capacity(6'd2);                         // table far above capacity
        send_request(OP_ADD, 32'd3, 1'b1);
        send_request(OP_ADD, 32'd4, 1'b0);
    endtask

    task automatic test_random(int n);
        logic [31:0] base_v;
        int          r;
        base_v = $urandom();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 60) send_request(OP_ADD, pick_step(base_v), $urandom_range(19, 0) == 0);
            else if (r < 78) send_request(OP_ERASE, pick_step(base_v), 1'($urandom()));
            else if (r < 97) send_request(OP_CONTAINS, pick_step(base_v), 1'($urandom()));
            else begin
                send_request(OP_CLEAR, $urandom(), 1'($urandom()));
                base_v = $urandom();
            end
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_back_pressure();
        stall_long = 1'b1;
        fork
            begin
                repeat (2) @(posedge m_axis_tready);
                stall_long = 1'b0;
            end
            test_random(12);
        join
    endtask

    initial begin
        n_errors = 0;
        tbl_n = 0; tbl_extra = 0; tbl_base = 8;
        stall_long = 1'b0;
        idle_max = 18;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity_extremes();
        test_back_pressure();
        write_capacity(6'd32);
        test_random(350);
        write_capacity(6'd5);
        idle_max = 0;                                 // back-to-back stretch
        test_random(300);
        idle_max = 18;
        write_capacity(6'd12);
        test_random(400);
        write_capacity(6'd3);
        test_random(350);
        drain();
        if (n_errors == 0 && pending_q.size() == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/cksr_pkg.sv
design/cksr_mem.sv
design/cksr_mul.sv
design/checkpoint_slot_replacement_core.sv
design/cksr_chk.sv
bench/tb.sv
